FILE: hdl/crc_framed_packet_parser_top_macros.svh
// Assertion helpers for the parser modules; cfpp_back includes them.
// Both expect clk and rst_n in scope.
`ifndef CRC_FRAMED_PACKET_PARSER_TOP_MACROS_SVH
`define CRC_FRAMED_PACKET_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define CFPP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFPP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cfpp_pkg.sv
`timescale 1ns / 1ps

package cfpp_pkg;

    localparam int PAYLOAD_MAX = 64;
    localparam int PAYLOAD_AW  = $clog2(PAYLOAD_MAX);
    localparam int LEN_W       = $clog2(PAYLOAD_MAX + 1);
    localparam int HEADER_LEN  = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [1:0] REG_START_FIRST  = 2'd0;
    localparam logic [1:0] REG_START_SECOND = 2'd1;
    localparam logic [1:0] REG_VERSION      = 2'd2;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ERR  = 2'd1,
        CMD_OK   = 2'd2
    } cmd_kind_t;

    // one command per accepted byte, front to back
    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       pkt_type;
        logic [7:0]       seq_number;
        logic [LEN_W-1:0] payload_length;
    } cmd_t;

    typedef struct packed {
        logic                  en;
        logic [PAYLOAD_AW-1:0] addr;
        logic [7:0]            data;
    } mem_wr_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [7:0]            pkt_type;
        logic [7:0]            seq_number;
        logic [LEN_W-1:0]      payload_length;
        logic [7:0]            payload_byte;
        logic [PAYLOAD_AW-1:0] byte_index;
        logic                  last;
    } result_t;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: hdl/cfpp_cmd_fifo.sv
`timescale 1ns / 1ps

module cfpp_cmd_fifo
    import cfpp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t pop_data
);

    cmd_t              slots_reg [CMD_DEPTH];
    logic [CMD_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_AW:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == (CMD_AW + 1)'(CMD_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = slots_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: hdl/cfpp_front.sv
`timescale 1ns / 1ps

module cfpp_front
    import cfpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       cfg_valid,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       cmd_full,
    output logic       cmd_push,
    output cmd_t       cmd_data,
    output mem_wr_t    mem_wr,
    input  logic       run_done
);

    typedef enum logic [4:0] {
        PH_SOF_A    = 5'b00001,
        PH_SOF_B    = 5'b00010,
        PH_HEADER   = 5'b00100,
        PH_PAYLOAD  = 5'b01000,
        PH_CRC      = 5'b10000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [2:0]       header_count_reg, header_count_next;
    logic [7:0]       frame_type_reg, frame_type_next;
    logic [7:0]       frame_seq_reg, frame_seq_next;
    logic [15:0]      frame_length_reg, frame_length_next;
    logic [LEN_W-1:0] payload_count_reg, payload_count_next;
    logic [15:0]      running_crc_reg, running_crc_next;
    logic [7:0]       crc_low_byte_reg, crc_low_byte_next;
    logic             crc_count_reg, crc_count_next;
    logic             version_ok_reg, version_ok_next;
    logic             run_pending_reg, run_pending_next;
    logic [7:0]       start_first_reg, start_second_reg, version_reg;

    logic             accept;
    logic             do_clear, go_sof_b, run_set;

    // payload writes wait until the previous frame has been read out
    assign full     = cmd_full || ((phase_reg == PH_PAYLOAD) && run_pending_reg);
    assign accept   = push && !full;
    assign cmd_push = accept;

    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        frame_type_next    = frame_type_reg;
        frame_seq_next     = frame_seq_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        running_crc_next   = running_crc_reg;
        crc_low_byte_next  = crc_low_byte_reg;
        crc_count_next     = crc_count_reg;
        version_ok_next    = version_ok_reg;
        do_clear           = 1'b0;
        go_sof_b           = 1'b0;
        run_set            = 1'b0;
        cmd_data           = '{kind: CMD_NONE, pkt_type: '0, seq_number: '0,
                               payload_length: '0};
        mem_wr             = '{en: 1'b0, addr: payload_count_reg[PAYLOAD_AW-1:0],
                               data: in_byte};

        if (accept)
        begin
            case (phase_reg)
                PH_SOF_A:
                begin
                    if (in_byte == start_first_reg)
                    begin
                        do_clear = 1'b1;
                        go_sof_b = 1'b1;
                    end
                end
                PH_SOF_B:
                begin
                    if (in_byte == start_second_reg)
                    begin
                        phase_next        = PH_HEADER;
                        header_count_next = '0;
                    end
                    else if (in_byte != start_first_reg)
                    begin
                        do_clear = 1'b1;
                    end
                end
                PH_HEADER:
                begin
                    running_crc_next = crc16_byte(running_crc_reg, in_byte);
                    case (header_count_reg)
                        3'd0:    version_ok_next = (in_byte == version_reg);
                        3'd1:    frame_type_next = in_byte;
                        3'd2:    frame_seq_next  = in_byte;
                        3'd3:    frame_length_next = {frame_length_reg[15:8], in_byte};
                        default: frame_length_next = {in_byte, frame_length_reg[7:0]};
                    endcase
                    if (header_count_reg == 3'(HEADER_LEN - 1))
                    begin
                        header_count_next  = '0;
                        payload_count_next = '0;
                        if (!version_ok_next || frame_length_next > 16'(PAYLOAD_MAX))
                        begin
                            do_clear      = 1'b1;
                            cmd_data.kind = CMD_ERR;
                        end
                        else if (frame_length_next == 16'h0000)
                            phase_next = PH_CRC;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                    else
                    begin
                        header_count_next = header_count_reg + 3'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    running_crc_next   = crc16_byte(running_crc_reg, in_byte);
                    mem_wr.en          = (payload_count_reg < LEN_W'(PAYLOAD_MAX));
                    payload_count_next = payload_count_reg + 1'b1;
                    if (16'(payload_count_next) >= frame_length_reg)
                    begin
                        payload_count_next = '0;
                        crc_count_next     = 1'b0;
                        phase_next         = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    if (!crc_count_reg)
                    begin
                        crc_low_byte_next = in_byte;
                        crc_count_next    = 1'b1;
                    end
                    else
                    begin
                        do_clear = 1'b1;
                        if ({in_byte, crc_low_byte_reg} != running_crc_reg)
                            cmd_data.kind = CMD_ERR;
                        else
                        begin
                            cmd_data.kind           = CMD_OK;
                            cmd_data.pkt_type       = frame_type_reg;
                            cmd_data.seq_number     = frame_seq_reg;
                            cmd_data.payload_length = frame_length_reg[LEN_W-1:0];
                            run_set = (frame_length_reg != 16'h0000);
                        end
                    end
                end
                default:
                begin
                    do_clear = 1'b1;
                end
            endcase

            if (do_clear)
            begin
                phase_next         = PH_SOF_A;
                header_count_next  = '0;
                frame_type_next    = '0;
                frame_seq_next     = '0;
                frame_length_next  = '0;
                payload_count_next = '0;
                running_crc_next   = CRC_INIT;
                crc_low_byte_next  = '0;
                crc_count_next     = 1'b0;
                version_ok_next    = 1'b0;
            end
            if (go_sof_b)
                phase_next = PH_SOF_B;
        end

        run_pending_next = run_pending_reg;
        if (run_done)
            run_pending_next = 1'b0;
        if (run_set)
            run_pending_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SOF_A;
            header_count_reg  <= '0;
            frame_type_reg    <= '0;
            frame_seq_reg     <= '0;
            frame_length_reg  <= '0;
            payload_count_reg <= '0;
            running_crc_reg   <= CRC_INIT;
            crc_low_byte_reg  <= '0;
            crc_count_reg     <= 1'b0;
            version_ok_reg    <= 1'b0;
            run_pending_reg   <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            frame_type_reg    <= frame_type_next;
            frame_seq_reg     <= frame_seq_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
            running_crc_reg   <= running_crc_next;
            crc_low_byte_reg  <= crc_low_byte_next;
            crc_count_reg     <= crc_count_next;
            version_ok_reg    <= version_ok_next;
            run_pending_reg   <= run_pending_next;
        end
    end

    // config registers; index 3 is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_first_reg  <= 8'hAA;
            start_second_reg <= 8'h55;
            version_reg      <= 8'h01;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_FIRST:  start_first_reg  <= cfg_data;
                REG_START_SECOND: start_second_reg <= cfg_data;
                REG_VERSION:      version_reg      <= cfg_data;
                default:          ;
            endcase
        end
    end

endmodule

FILE: hdl/cfpp_back.sv
`timescale 1ns / 1ps

module cfpp_back
    import cfpp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd_data,
    output logic    cmd_pop,
    input  mem_wr_t mem_wr,
    output logic    run_done,
    output logic    res_valid,
    output result_t res_data,
    input  logic    res_pop
);

    `include "crc_framed_packet_parser_top_macros.svh"

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_READ = 3'b010,
        BK_EMIT = 3'b100
    } back_state_t;

    back_state_t           state_reg, state_next;
    logic [7:0]            payload_mem [PAYLOAD_MAX];
    logic [7:0]            rd_data_reg;
    logic                  rd_en;
    logic [7:0]            run_type_reg, run_type_next;
    logic [7:0]            run_seq_reg, run_seq_next;
    logic [LEN_W-1:0]      run_len_reg, run_len_next;
    logic [PAYLOAD_AW-1:0] idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;
    logic                  out_free, idx_last;
    logic                  res_single, single_clean;
    logic                  res_run_last, last_idx_match;
    logic                  emit_in_range, run_last_shown;

    assign out_free  = !out_valid_reg || res_pop;
    assign idx_last  = (LEN_W'(idx_reg) == run_len_reg - 1'b1);
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        run_type_next  = run_type_reg;
        run_seq_next   = run_seq_reg;
        run_len_next   = run_len_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !res_pop;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        rd_en          = 1'b0;
        run_done       = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_data.kind == CMD_OK && cmd_data.payload_length != '0)
                    begin
                        cmd_pop       = 1'b1;
                        run_type_next = cmd_data.pkt_type;
                        run_seq_next  = cmd_data.seq_number;
                        run_len_next  = cmd_data.payload_length;
                        idx_next      = '0;
                        state_next    = BK_READ;
                    end
                    else if (out_free)
                    begin
                        cmd_pop        = 1'b1;
                        out_valid_next = 1'b1;
                        out_next       = '{status: ST_NONE, pkt_type: '0, seq_number: '0,
                                           payload_length: '0, payload_byte: '0,
                                           byte_index: '0, last: 1'b1};
                        if (cmd_data.kind == CMD_ERR)
                            out_next.status = ST_ERR;
                        else if (cmd_data.kind == CMD_OK)
                        begin
                            // empty payload: one result, header fields only
                            out_next.status     = ST_OK;
                            out_next.pkt_type   = cmd_data.pkt_type;
                            out_next.seq_number = cmd_data.seq_number;
                        end
                    end
                end
            end
            BK_READ:
            begin
                rd_en      = 1'b1;
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{status: ST_OK, pkt_type: run_type_reg,
                                       seq_number: run_seq_reg, payload_length: run_len_reg,
                                       payload_byte: rd_data_reg, byte_index: idx_reg,
                                       last: idx_last};
                    if (idx_last)
                    begin
                        run_done   = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            run_len_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            run_len_reg   <= run_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_type_reg <= run_type_next;
        run_seq_reg  <= run_seq_next;
        out_reg      <= out_next;
    end

    // payload buffer: front writes, read-out reads
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
            payload_mem[mem_wr.addr] <= mem_wr.data;
        if (rd_en)
            rd_data_reg <= payload_mem[idx_reg];
    end

    assign res_single     = out_valid_reg && out_reg.status != ST_OK;
    assign single_clean   = out_reg.last && out_reg.pkt_type == 8'h00
                            && out_reg.payload_length == '0;
    assign res_run_last   = out_valid_reg && out_reg.status == ST_OK && out_reg.last
                            && out_reg.payload_length != '0;
    assign last_idx_match = (LEN_W'(out_reg.byte_index) == out_reg.payload_length - 1'b1);
    assign emit_in_range  = run_len_reg != '0 && LEN_W'(idx_reg) < run_len_reg;
    assign run_last_shown = out_valid_reg && out_reg.last && out_reg.status == ST_OK;

    `CFPP_ASSERT_IMP(a_single_result_fields, res_single, single_clean, "none/error result carries data")
    `CFPP_ASSERT_IMP(a_run_last_index, res_run_last, last_idx_match, "last flag off final byte")
    `CFPP_ASSERT_IMP(a_emit_in_range, state_reg == BK_EMIT, emit_in_range, "index past length")
    `CFPP_ASSERT_NXT(a_done_shows_last, run_done, run_last_shown, "run end without last result")

endmodule

FILE: hdl/crc_framed_packet_parser_top.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+----------------------------------
// input     | in        | push / full              | in_byte
// result    | out       | empty / pop              | status, pkt_type, seq_number,
//           |           |                          | payload_length, payload_byte,
//           |           |                          | byte_index, last
// config    | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One byte is taken per cycle while the 4-entry command queue has room; each byte
// gives one command. A good frame reads its payload out one result at a time, each
// through a buffer read and then the output register. A byte in the payload phase
// of the next frame is held off (full) until the previous frame's read-out is done.
// rst_n is asynchronous; the payload buffer needs no clearing pass.

module crc_framed_packet_parser_top
    import cfpp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            in_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            status,
    output logic [7:0]            pkt_type,
    output logic [7:0]            seq_number,
    output logic [LEN_W-1:0]      payload_length,
    output logic [7:0]            payload_byte,
    output logic [PAYLOAD_AW-1:0] byte_index,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);

    cmd_t    push_cmd, head_cmd;
    logic    cmd_push, cmd_full, cmd_valid, cmd_pop;
    mem_wr_t mem_wr;
    logic    run_done;
    logic    res_valid;
    result_t res_data;

    assign cfg_ready = 1'b1;

    cfpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_data  (push_cmd),
        .mem_wr    (mem_wr),
        .run_done  (run_done)
    );

    cfpp_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .valid     (cmd_valid),
        .pop_data  (head_cmd)
    );

    cfpp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_data  (head_cmd),
        .cmd_pop   (cmd_pop),
        .mem_wr    (mem_wr),
        .run_done  (run_done),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_pop   (pop)
    );

    assign empty          = !res_valid;
    assign status         = res_data.status;
    assign pkt_type       = res_data.pkt_type;
    assign seq_number     = res_data.seq_number;
    assign payload_length = res_data.payload_length;
    assign payload_byte   = res_data.payload_byte;
    assign byte_index     = res_data.byte_index;
    assign last           = res_data.last;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import cfpp_pkg::*;

    localparam logic [1:0] REG_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        IN_HEADER,
        IN_PAYLOAD,
        IN_CRC
    } parse_phase_t;

    typedef enum logic [1:0] {
        ROW_DATA,
        ROW_CRC_LO,
        ROW_CRC_HI
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] data;
        logic       typed;
        logic [1:0] st;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            in_byte = 8'h00;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [1:0]            status;
    logic [7:0]            pkt_type;
    logic [7:0]            seq_number;
    logic [LEN_W-1:0]      payload_length;
    logic [7:0]            payload_byte;
    logic [PAYLOAD_AW-1:0] byte_index;
    logic                  last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = 2'd0;
    logic [7:0]            cfg_data = 8'h00;

    // parser model state and register copies
    logic [7:0]   sof_first = 8'hAA;
    logic [7:0]   sof_second = 8'h55;
    logic [7:0]   want_version = 8'h01;
    parse_phase_t ph;
    int           hdr_cnt;
    int           pay_cnt;
    logic [7:0]   f_type;
    logic [7:0]   f_seq;
    logic [15:0]  f_len;
    logic [15:0]  run_crc;
    logic [7:0]   crc_lo;
    bit           crc_half;
    bit           ver_ok;
    logic [7:0]   pay_buf [0:PAYLOAD_MAX-1];

    result_t      results_due [$];
    result_t      step_results [$];
    int           mismatches = 0;
    int           cycles = 0;
    bit           idle_en = 1'b1;
    bit           rx_hold_req = 1'b0;
    int           hold_left = 0;

    // directed frames: wrong second start, repeated first start, bad version,
    // oversize length, then a good one-byte frame with extreme header fields
    dir_row_t dir_tab [0:26] = '{
        '{ROW_DATA,   8'hAA, 1'b1, ST_NONE},
        '{ROW_DATA,   8'h12, 1'b1, ST_NONE},
        '{ROW_DATA,   8'hAA, 1'b0, ST_NONE},
        '{ROW_DATA,   8'hAA, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h55, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h02, 1'b0, ST_NONE},
        '{ROW_DATA,   8'hFF, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h00, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h00, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h00, 1'b1, ST_ERR},
        '{ROW_DATA,   8'hAA, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h55, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h01, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h00, 1'b0, ST_NONE},
        '{ROW_DATA,   8'hFF, 1'b0, ST_NONE},
        '{ROW_DATA,   8'hFF, 1'b0, ST_NONE},
        '{ROW_DATA,   8'hFF, 1'b1, ST_ERR},
        '{ROW_DATA,   8'hAA, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h55, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h01, 1'b0, ST_NONE},
        '{ROW_DATA,   8'hFF, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h00, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h01, 1'b0, ST_NONE},
        '{ROW_DATA,   8'h00, 1'b0, ST_NONE},
        '{ROW_DATA,   8'hFF, 1'b0, ST_NONE},
        '{ROW_CRC_LO, 8'h00, 1'b0, ST_NONE},
        '{ROW_CRC_HI, 8'h00, 1'b0, ST_NONE}
    };

    crc_framed_packet_parser_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .in_byte        (in_byte),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .pkt_type       (pkt_type),
        .seq_number     (seq_number),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // bit-serial CRC-16, poly 0x1021, MSB first
    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void restart_frame();
        ph = HUNT_FIRST;
        hdr_cnt = 0;
        pay_cnt = 0;
        f_type = 8'h00;
        f_seq = 8'h00;
        f_len = 16'h0000;
        run_crc = CRC_INIT;
        crc_lo = 8'h00;
        crc_half = 1'b0;
        ver_ok = 1'b0;
    endfunction

    // advance the parser model by one byte; results go to step_results
    task automatic parse_byte(input logic [7:0] b);
        result_t r;
        bit      many;
        r = '0;
        r.status = ST_NONE;
        r.last = 1'b1;
        many = 1'b0;
        step_results.delete();
        case (ph)
            HUNT_FIRST:
            begin
                if (b == sof_first)
                begin
                    restart_frame();
                    ph = HUNT_SECOND;
                end
            end
            HUNT_SECOND:
            begin
                // second start byte wins when both match
                if (b == sof_second)
                begin
                    ph = IN_HEADER;
                    hdr_cnt = 0;
                end
                else if (b != sof_first)
                    restart_frame();
            end
            IN_HEADER:
            begin
                run_crc = crc_next(run_crc, b);
                case (hdr_cnt)
                    0: ver_ok = (b == want_version);
                    1: f_type = b;
                    2: f_seq = b;
                    3: f_len[7:0] = b;
                    default: f_len[15:8] = b;
                endcase
                hdr_cnt++;
                if (hdr_cnt >= HEADER_LEN)
                begin
                    hdr_cnt = 0;
                    pay_cnt = 0;
                    if (!ver_ok || f_len > PAYLOAD_MAX)
                    begin
                        restart_frame();
                        r.status = ST_ERR;
                    end
                    else
                        ph = (f_len == 16'h0000) ? IN_CRC : IN_PAYLOAD;
                end
            end
            IN_PAYLOAD:
            begin
                run_crc = crc_next(run_crc, b);
                pay_buf[pay_cnt] = b;
                pay_cnt++;
                if (pay_cnt >= f_len)
                begin
                    pay_cnt = 0;
                    crc_half = 1'b0;
                    ph = IN_CRC;
                end
            end
            default:
            begin
                if (!crc_half)
                begin
                    crc_lo = b;
                    crc_half = 1'b1;
                end
                else if ({b, crc_lo} != run_crc)
                begin
                    restart_frame();
                    r.status = ST_ERR;
                end
                else if (f_len == 16'h0000)
                begin
                    r.status = ST_OK;
                    r.pkt_type = f_type;
                    r.seq_number = f_seq;
                    restart_frame();
                end
                else
                begin
                    many = 1'b1;
                    for (int k = 0; k < f_len; k++)
                    begin
                        r.status = ST_OK;
                        r.pkt_type = f_type;
                        r.seq_number = f_seq;
                        r.payload_length = LEN_W'(f_len);
                        r.payload_byte = pay_buf[k];
                        r.byte_index = PAYLOAD_AW'(k);
                        r.last = (k == f_len - 1);
                        step_results.push_back(r);
                    end
                    restart_frame();
                end
            end
        endcase
        if (!many)
            step_results.push_back(r);
    endtask

    // offer one byte; expectations are queued once the transaction completes
    task automatic send_byte(input logic [7:0] b, input bit typed, input logic [1:0] st);
        result_t r;
        if (idle_en && $urandom_range(0, 99) < 7)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        parse_byte(b);
        if (typed)
        begin
            r = '0;
            r.status = st;
            r.last = 1'b1;
            results_due.push_back(r);
        end
        else
        begin
            foreach (step_results[i])
                results_due.push_back(step_results[i]);
        end
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_START_FIRST:  sof_first = val;
            REG_START_SECOND: sof_second = val;
            REG_VERSION:      want_version = val;
            default:          ;
        endcase
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // mostly well-formed frames with random content, some broken ones and noise
    task automatic random_traffic(input int target, input bit force_max);
        logic [7:0]  burst [$];
        logic [15:0] crc;
        logic [15:0] len;
        logic [7:0]  ver;
        logic [7:0]  b;
        int          sel;
        int          sent;
        sent = 0;
        while (sent < target)
        begin
            burst.delete();
            sel = force_max ? 99 : $urandom_range(0, 99);
            if (sel < 6)
            begin
                repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom));
            end
            else if (sel < 12)
            begin
                do
                    b = 8'($urandom);
                while (b == sof_first || b == sof_second);
                burst.push_back(sof_first);
                burst.push_back(b);
            end
            else
            begin
                if (force_max)
                    len = 16'(PAYLOAD_MAX);
                else if (sel < 24 && sel >= 18)
                    len = 16'($urandom_range(PAYLOAD_MAX + 1, 65535));
                else if ($urandom_range(0, 99) < 90)
                    len = 16'($urandom_range(0, 6));
                else
                    len = 16'($urandom_range(7, PAYLOAD_MAX));
                ver = (sel < 18) ? want_version ^ 8'($urandom_range(1, 255)) : want_version;
                burst.push_back(sof_first);
                if (sof_first != sof_second && $urandom_range(0, 9) == 0)
                    burst.push_back(sof_first);
                burst.push_back(sof_second);
                burst.push_back(ver);
                burst.push_back(8'($urandom));
                burst.push_back(8'($urandom));
                burst.push_back(len[7:0]);
                burst.push_back(len[15:8]);
                // header errors end the frame right after the length
                if (sel >= 24)
                begin
                    crc = CRC_INIT;
                    for (int i = burst.size() - 5; i < burst.size(); i++)
                        crc = crc_next(crc, burst[i]);
                    for (int i = 0; i < len; i++)
                    begin
                        b = 8'($urandom);
                        crc = crc_next(crc, b);
                        burst.push_back(b);
                    end
                    if (sel < 32)
                        crc = crc ^ 16'($urandom_range(1, 65535));
                    burst.push_back(crc[7:0]);
                    burst.push_back(crc[15:8]);
                end
            end
            force_max = 1'b0;
            foreach (burst[i])
                send_byte(burst[i], 1'b0, ST_NONE);
            sent += burst.size();
        end
    endtask

    // result side: check each transaction, then choose pop for the next cycle
    always @(posedge clk)
    begin
        result_t act;
        result_t want;
        bit      have;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                act.status = status;
                act.pkt_type = pkt_type;
                act.seq_number = seq_number;
                act.payload_length = payload_length;
                act.payload_byte = payload_byte;
                act.byte_index = byte_index;
                act.last = last;
                have = (results_due.size() != 0);
                want = have ? results_due.pop_front() : 'x;
                if (!have || act !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch%s: exp st=%0d ty=%h sq=%h len=%0d pb=%h idx=%0d last=%b",
                                 have ? "" : " (nothing expected)",
                                 want.status, want.pkt_type, want.seq_number,
                                 want.payload_length, want.payload_byte,
                                 want.byte_index, want.last);
                        $display("          act st=%0d ty=%h sq=%h len=%0d pb=%h idx=%0d last=%b",
                                 act.status, act.pkt_type, act.seq_number,
                                 act.payload_length, act.payload_byte,
                                 act.byte_index, act.last);
                    end
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else
                pop <= !(idle_en && $urandom_range(0, 99) < 7);
        end
    end

    initial
    begin
        logic [7:0] b;
        restart_frame();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            case (dir_tab[i].kind)
                ROW_CRC_LO: b = run_crc[7:0];
                ROW_CRC_HI: b = run_crc[15:8];
                default:    b = dir_tab[i].data;
            endcase
            send_byte(b, dir_tab[i].typed, dir_tab[i].st);
        end

        // receiver stalls a long while so the input side backs up
        rx_hold_req = 1'b1;
        random_traffic(1, 1'b1);
        settle();

        set_reg(REG_START_FIRST, 8'h00);
        set_reg(REG_START_SECOND, 8'hFF);
        set_reg(REG_VERSION, 8'hFF);
        set_reg(REG_IGNORED, 8'($urandom));
        idle_en = 1'b0;
        random_traffic(6, 1'b0);
        settle();
        idle_en = 1'b1;

        set_reg(REG_START_FIRST, 8'hFF);
        set_reg(REG_START_SECOND, 8'h00);
        set_reg(REG_VERSION, 8'h00);
        random_traffic(6, 1'b0);
        settle();

        // both start bytes equal
        b = 8'($urandom);
        set_reg(REG_START_FIRST, b);
        set_reg(REG_START_SECOND, b);
        set_reg(REG_VERSION, 8'($urandom));
        random_traffic(6, 1'b0);
        settle();
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
